[rtl/tmmf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register codes and transaction types of the tiled minimum finder.
package tmmf_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 4096;
  localparam int unsigned WINDOW_DEF     = 50;

  localparam int unsigned DIST_W = 24;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned FC_W   = 13;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OUT_DEPTH   = 4;

  // 9999.0 in UQ16.8
  localparam logic [DIST_W-1:0] SENTINEL = 24'd2559744;

  typedef enum logic {
    REG_FRAME_COUNT   = 1'b0,
    REG_MIN_THRESHOLD = 1'b1
  } reg_idx_e;

  // One classified matrix element on its way from front to back
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [DIST_W-1:0] distance;
    logic              diag;
    logic              last;
  } elem_t;

  // Tile record and result transaction
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [DIST_W-1:0] value;
  } result_t;

endpackage

[rtl/tmmf_fifo.sv]
`timescale 1ns / 1ps
// Small register-based FIFO used between the front, back and result ports.
module tmmf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [CntW-1:0]  count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/tmmf_front.sv]
`timescale 1ns / 1ps
// Front end: tracks matrix position and tags each element with tile, diagonal and tile end.
module tmmf_front #(
  parameter int unsigned MaxFrames = 4096,
  parameter int unsigned Window    = 50,
  parameter int unsigned TileW     = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [tmmf_pkg::FC_W-1:0]   frame_count_i,
  input  logic                        step_i,
  input  logic [tmmf_pkg::DIST_W-1:0] distance_i,
  output tmmf_pkg::elem_t             elem_o,
  output logic [TileW-1:0]            tile_o
);
  import tmmf_pkg::*;

  localparam int unsigned CntW = $clog2(MaxFrames);
  localparam int unsigned WinW = $clog2(Window);
  localparam logic [WinW-1:0] WinLast = WinW'(Window - 1);

  logic [CntW-1:0]  row_q, col_q, last_idx;
  logic [WinW-1:0]  row_win_q, col_win_q;
  logic [TileW-1:0] tile_q;
  logic [31:0]      fc_ext;
  logic             end_row, end_col, win_row_last, win_col_last;

  // Clamp the side length into 1..MaxFrames and keep its last index
  always_comb begin
    fc_ext = 32'(frame_count_i);
    if (fc_ext == 32'd0) begin
      last_idx = '0;
    end else if (fc_ext > MaxFrames) begin
      last_idx = CntW'(MaxFrames - 1);
    end else begin
      last_idx = CntW'(fc_ext - 32'd1);
    end
  end

  assign end_row      = (row_q == last_idx);
  assign end_col      = (col_q == last_idx);
  assign win_row_last = (row_win_q == WinLast);
  assign win_col_last = (col_win_q == WinLast);

  always_comb begin
    elem_o.row      = POS_W'(row_q);
    elem_o.col      = POS_W'(col_q);
    elem_o.distance = distance_i;
    elem_o.diag     = (row_q == col_q);
    elem_o.last     = (win_row_last || end_row) && (win_col_last || end_col);
  end

  assign tile_o = tile_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      row_win_q <= '0;
      col_win_q <= '0;
      tile_q    <= '0;
    end else if (restart_i) begin
      row_q     <= '0;
      col_q     <= '0;
      row_win_q <= '0;
      col_win_q <= '0;
      tile_q    <= '0;
    end else if (step_i) begin
      if (end_col) begin
        col_q     <= '0;
        col_win_q <= '0;
        tile_q    <= '0;
        if (end_row) begin
          row_q     <= '0;
          row_win_q <= '0;
        end else begin
          row_q     <= row_q + 1'b1;
          row_win_q <= win_row_last ? '0 : row_win_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
        if (win_col_last) begin
          col_win_q <= '0;
          tile_q    <= tile_q + 1'b1;
        end else begin
          col_win_q <= col_win_q + 1'b1;
        end
      end
    end
  end

endmodule

[rtl/tmmf_back.sv]
`timescale 1ns / 1ps
// Back end: per-tile record memory, compare and update, tile-end result issue.
module tmmf_back #(
  parameter int unsigned TileDepth = 82,
  parameter int unsigned TileW     = 7,
  parameter int unsigned OutDepth  = 4,
  parameter int unsigned OutCntW   = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic                        q_empty_i,
  input  tmmf_pkg::elem_t             q_elem_i,
  input  logic [TileW-1:0]            q_tile_i,
  output logic                        q_pop_o,
  input  logic [OutCntW-1:0]          out_count_i,
  input  logic [tmmf_pkg::DIST_W-1:0] threshold_i,
  output logic                        res_push_o,
  output tmmf_pkg::result_t           res_o
);
  import tmmf_pkg::*;

  result_t          rec_mem [TileDepth];
  logic [TileDepth-1:0] found_q;

  logic             u_valid_q;
  elem_t            u_elem_q;
  logic [TileW-1:0] u_tile_q;
  logic             u_found_q;
  result_t          rd_q;
  logic             fwd_q;
  result_t          fwd_rec_q;
  logic             fwd_found_q;

  logic              take;
  logic              cur_found, upd, new_found, kept_found, wr_en;
  result_t           cur_rec, new_rec;
  logic [DIST_W-1:0] cur_val;

  // Take an element only when the result FIFO has room for it and the one in flight
  assign take    = !q_empty_i && ((32'(out_count_i) + 32'(u_valid_q)) < OutDepth);
  assign q_pop_o = take;

  always_comb begin
    cur_found = fwd_q ? fwd_found_q : u_found_q;
    cur_rec   = fwd_q ? fwd_rec_q : rd_q;
    cur_val   = cur_found ? cur_rec.value : SENTINEL;
    upd       = !u_elem_q.diag && (u_elem_q.distance < cur_val);
    new_found = cur_found || upd;
    if (upd) begin
      new_rec.row   = u_elem_q.row;
      new_rec.col   = u_elem_q.col;
      new_rec.value = u_elem_q.distance;
    end else begin
      new_rec = cur_rec;
    end
    kept_found = new_found && !u_elem_q.last;
    wr_en      = u_valid_q && upd && !u_elem_q.last;
  end

  assign res_push_o = u_valid_q && u_elem_q.last && new_found && (new_rec.value < threshold_i);
  assign res_o      = new_rec;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[u_tile_q] <= new_rec;
    end
    if (take) begin
      rd_q <= rec_mem[q_tile_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_valid_q <= 1'b0;
      found_q   <= '0;
    end else if (restart_i) begin
      u_valid_q <= 1'b0;
      found_q   <= '0;
    end else begin
      u_valid_q <= take;
      if (u_valid_q) begin
        found_q[u_tile_q] <= kept_found;
      end
    end
  end

  // Bypass the record written this cycle when the next element hits the same tile
  always_ff @(posedge clk_i) begin
    if (take) begin
      u_elem_q    <= q_elem_i;
      u_tile_q    <= q_tile_i;
      u_found_q   <= found_q[q_tile_i];
      fwd_q       <= u_valid_q && (u_tile_q == q_tile_i);
      fwd_rec_q   <= new_rec;
      fwd_found_q <= kept_found;
    end
  end

endmodule

[rtl/tiled_matrix_minimum_finder_unit.sv]
`timescale 1ns / 1ps
// Top level of the tiled minimum finder: register port, front, queue, back, result FIFO.
//
// Usage:
//  - Stream a square distance matrix, row-major, one UQ16.8 element per input
//    transaction (push/full). Tiles are Window x Window, clipped at the edges.
//  - At the last element of each tile the smallest off-diagonal element is
//    issued as a result transaction (empty/pop) when strictly below
//    min_threshold. Tiles with no qualifying element issue nothing.
//  - Throughput is one element per cycle when not stalled: the front counters
//    advance on each accepted push, and the back does one read-compare-write
//    of the tile record memory per cycle, with a bypass for back-to-back same-tile hits.
//  - A result passes the input queue, the back's update register and the
//    result FIFO before it shows on the result ports.
//  - When pop is held low, the result FIFO fills; the back stops taking
//    elements once it could overflow, the front queue fills and full rises.
//  - Reset clears the counters, the found flags of all tile records and both queues;
//    frame_count returns to MaxFrames and min_threshold to 9999.0. Writing frame_count
//    restarts counters and flags, not queues. Write registers only while idle.
//  - Registers: frame_count at byte 0, min_threshold at byte 4.
module tiled_matrix_minimum_finder_unit #(
  parameter int unsigned MaxFrames = tmmf_pkg::MAX_FRAMES_DEF,
  parameter int unsigned Window    = tmmf_pkg::WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [tmmf_pkg::DIST_W-1:0] distance_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [tmmf_pkg::POS_W-1:0]  min_row_o,
  output logic [tmmf_pkg::POS_W-1:0]  min_col_o,
  output logic [tmmf_pkg::DIST_W-1:0] min_value_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmmf_pkg::APB_AW-1:0] paddr,
  input  logic [tmmf_pkg::APB_DW-1:0] pwdata,
  output logic [tmmf_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import tmmf_pkg::*;

  localparam int unsigned TileDepth = (MaxFrames + Window - 1) / Window;
  localparam int unsigned TileW     = (TileDepth > 1) ? $clog2(TileDepth) : 1;
  localparam int unsigned QW        = TileW + $bits(elem_t);
  localparam int unsigned OutCntW   = $clog2(OUT_DEPTH + 1);

  // Configuration registers
  logic [FC_W-1:0]   fc_q;
  logic [DIST_W-1:0] thr_q;
  logic              cfg_wr, restart;
  reg_idx_e          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && (reg_sel == REG_FRAME_COUNT);

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_COUNT:   prdata = APB_DW'(fc_q);
      REG_MIN_THRESHOLD: prdata = APB_DW'(thr_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q  <= FC_W'(MaxFrames);
      thr_q <= SENTINEL;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FRAME_COUNT:   fc_q  <= pwdata[FC_W-1:0];
        REG_MIN_THRESHOLD: thr_q <= pwdata[DIST_W-1:0];
        default:           ;
      endcase
    end
  end

  // Front: classify each accepted element
  elem_t            f_elem;
  logic [TileW-1:0] f_tile;
  logic             accept;

  assign accept = push && !full;

  tmmf_front #(
    .MaxFrames(MaxFrames),
    .Window   (Window),
    .TileW    (TileW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .frame_count_i(fc_q),
    .step_i       (accept),
    .distance_i   (distance_i),
    .elem_o       (f_elem),
    .tile_o       (f_tile)
  );

  // Queue between front and back
  logic [QW-1:0]                   q_wdata, q_rdata;
  logic                            q_empty, q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  elem_t                           q_elem;
  logic [TileW-1:0]                q_tile;

  assign q_wdata = {f_tile, f_elem};
  assign q_tile  = q_rdata[QW-1 -: TileW];
  assign q_elem  = elem_t'(q_rdata[$bits(elem_t)-1:0]);

  tmmf_fifo #(
    .Width(QW),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .full_o (full),
    .empty_o(q_empty),
    .count_o(q_count)
  );

  // Back: tile record update and result issue
  logic              res_push;
  result_t           res;
  logic [OutCntW-1:0] out_count;

  tmmf_back #(
    .TileDepth(TileDepth),
    .TileW    (TileW),
    .OutDepth (OUT_DEPTH),
    .OutCntW  (OutCntW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .q_empty_i  (q_empty),
    .q_elem_i   (q_elem),
    .q_tile_i   (q_tile),
    .q_pop_o    (q_pop),
    .out_count_i(out_count),
    .threshold_i(thr_q),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // Result FIFO decouples the back from the consumer
  logic    out_full;
  result_t out_item;
  logic [$bits(result_t)-1:0] out_rdata;

  assign out_item = result_t'(out_rdata);

  tmmf_fifo #(
    .Width($bits(result_t)),
    .Depth(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .pop_i  (pop),
    .data_o (out_rdata),
    .full_o (out_full),
    .empty_o(empty),
    .count_o(out_count)
  );

  assign min_row_o   = out_item.row;
  assign min_col_o   = out_item.col;
  assign min_value_o = out_item.value;

  // Front queue depth is visible only through full; credit check keeps results from overflowing
  logic unused_status;
  assign unused_status = out_full ^ (|q_count) ^ (|paddr[1:0]);

endmodule

[rtl/tmmf_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the tiled minimum finder, bound to the top level.
module tmmf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [tmmf_pkg::POS_W-1:0]  min_row_o,
  input logic [tmmf_pkg::POS_W-1:0]  min_col_o,
  input logic [tmmf_pkg::DIST_W-1:0] min_value_o
);
  import tmmf_pkg::*;

  // Queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queues not empty during reset");

  // Diagonal elements are never reported
  a_no_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (min_row_o != min_col_o))
    else $error("diagonal element reported");

  // A reported minimum always beat the sentinel
  a_below_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (min_value_o < SENTINEL))
    else $error("reported value not below sentinel");

  // A waiting result stays until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped before pop");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(min_value_o) && $stable(min_row_o) && $stable(min_col_o)))
    else $error("stalled result changed");

endmodule

bind tiled_matrix_minimum_finder_unit tmmf_checker u_tmmf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .min_row_o  (min_row_o),
  .min_col_o  (min_col_o),
  .min_value_o(min_value_o)
);

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the tiled minimum finder with its own tile-record model.
module tb;
  import tmmf_pkg::*;

  localparam int unsigned WIN           = WINDOW_DEF;
  localparam int unsigned MAXF          = MAX_FRAMES_DEF;
  localparam int unsigned TILES         = (MAXF + WIN - 1) / WIN;
  // margin for a result to pass the queues after the tile's last element
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Tracks the frame position and the per-tile minimum records, and keeps the
  // tile minima that the block still owes, oldest first.
  class tile_minimum_tracker;
    logic [FC_W-1:0]   frame_count;
    logic [DIST_W-1:0] threshold;
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [DIST_W-1:0] best_value [TILES];
    logic [POS_W-1:0]  best_row   [TILES];
    logic [POS_W-1:0]  best_col   [TILES];
    bit                best_valid [TILES];
    result_t           owed_minima [$];
    int unsigned       predicted;
    int unsigned       mismatches;

    function new();
      frame_count = FC_W'(MAXF);
      threshold   = SENTINEL;
      predicted   = 0;
      mismatches  = 0;
      restart();
    endfunction

    function void drop_tile(int unsigned t);
      best_value[t] = SENTINEL;
      best_row[t]   = '0;
      best_col[t]   = '0;
      best_valid[t] = 1'b0;
    endfunction

    function void restart();
      row_pos = 0;
      col_pos = 0;
      foreach (best_value[t]) drop_tile(t);
    endfunction

    function void write_reg(reg_idx_e idx, logic [APB_DW-1:0] data);
      case (idx)
        REG_FRAME_COUNT: begin
          frame_count = data[FC_W-1:0];
          restart();
        end
        REG_MIN_THRESHOLD: begin
          threshold = data[DIST_W-1:0];
        end
      endcase
    endfunction

    function logic [APB_DW-1:0] read_reg(reg_idx_e idx);
      if (idx == REG_FRAME_COUNT) return APB_DW'(frame_count);
      return APB_DW'(threshold);
    endfunction

    function int unsigned pending();
      return owed_minima.size();
    endfunction

    function void take_distance(logic [DIST_W-1:0] d);
      int unsigned n;
      int unsigned r;
      int unsigned c;
      int unsigned t;
      bit          last_row;
      bit          last_col;
      result_t     found_min;
      n = 32'(frame_count);
      if (n == 0) n = 1;
      if (n > MAXF) n = MAXF;
      r = row_pos;
      c = col_pos;
      if (r >= n || c >= n) begin
        r = 0;
        c = 0;
      end
      t = c / WIN;
      if (t >= TILES) t = TILES - 1;
      // diagonal elements never take part; only a strictly smaller value wins
      if (r != c && d < best_value[t]) begin
        best_value[t] = d;
        best_row[t]   = POS_W'(r);
        best_col[t]   = POS_W'(c);
        best_valid[t] = 1'b1;
      end
      last_row = (r % WIN == WIN - 1) || (r == n - 1);
      last_col = (c % WIN == WIN - 1) || (c == n - 1);
      if (last_row && last_col) begin
        if (best_valid[t] && best_value[t] < threshold) begin
          found_min.row   = best_row[t];
          found_min.col   = best_col[t];
          found_min.value = best_value[t];
          owed_minima.insert(owed_minima.size(), found_min);
          predicted++;
        end
        drop_tile(t);
      end
      c++;
      if (c >= n) begin
        c = 0;
        r++;
        if (r >= n) r = 0;
      end
      row_pos = r;
      col_pos = c;
    endfunction

    function void compare_minimum(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                  logic [DIST_W-1:0] value);
      result_t exp_min;
      if (owed_minima.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual row %0d col %0d value %0d",
                 $time, row, col, value);
        mismatches++;
        return;
      end
      exp_min = owed_minima.pop_front();
      if (row !== exp_min.row) begin
        $display("%0t: min_row expected %0d actual %0d", $time, exp_min.row, row);
        mismatches++;
      end
      if (col !== exp_min.col) begin
        $display("%0t: min_col expected %0d actual %0d", $time, exp_min.col, col);
        mismatches++;
      end
      if (value !== exp_min.value) begin
        $display("%0t: min_value expected %0d actual %0d", $time, exp_min.value, value);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [DIST_W-1:0] distance_i;
  logic              empty;
  logic              pop;
  logic [POS_W-1:0]  min_row_o;
  logic [POS_W-1:0]  min_col_o;
  logic [DIST_W-1:0] min_value_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tile_minimum_tracker tracker = new();

  // idling knobs, set per phase by the main sequence
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // long receiver hold-off, counted down by the receiver process
  int unsigned pop_hold       = 0;

  tiled_matrix_minimum_finder_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .distance_i (distance_i),
    .empty      (empty),
    .pop        (pop),
    .min_row_o  (min_row_o),
    .min_col_o  (min_col_o),
    .min_value_o(min_value_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a transaction never completes.
  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

  // Receiver: decide pop at each falling edge. A pending hold-off wins over
  // the random stall so the output FIFO fills and backs up into the input.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (pop_hold > 0) begin
        pop_hold = pop_hold - 1;
        pop      = 1'b0;
      end else begin
        pop = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each result transaction at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      tracker.compare_minimum(min_row_o, min_col_o, min_value_o);
    end
  end

  // Mix small values (ties), values around the sentinel and the full range.
  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(9))
      0, 1:    return DIST_W'($urandom_range(0, 15));
      2, 3:    return DIST_W'($urandom_range(0, 4000));
      4, 5:    return DIST_W'($urandom_range(0, SENTINEL - 1));
      6:       return ($urandom_range(1) != 0) ? SENTINEL : DIST_W'(SENTINEL - 1);
      7, 8:    return DIST_W'($urandom);
      default: return ($urandom_range(1) != 0) ? DIST_MAX : '0;
    endcase
  endfunction

  // Mostly single-tile frames; a few degenerate and a few larger ones.
  function automatic int unsigned pick_side();
    case ($urandom_range(19))
      0:       return 0;
      1:       return 1;
      2, 3:    return $urandom_range(9, 14);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] pick_threshold();
    case ($urandom_range(19))
      0:                      return '0;
      1, 2:                   return DIST_W'($urandom_range(0, 20));
      3, 4, 5:                return SENTINEL;
      6, 7, 8, 9, 10, 11:     return DIST_W'($urandom_range(0, SENTINEL));
      default:                return DIST_MAX;
    endcase
  endfunction

  // Offer one element after a random gap; hold it until the block takes it.
  task automatic send_distance(input logic [DIST_W-1:0] d);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push       = 1'b0;
      distance_i = DIST_W'($urandom);
      @(negedge clk_i);
    end
    push       = 1'b1;
    distance_i = d;
    do @(posedge clk_i); while (full);
    tracker.take_distance(d);
  endtask

  task automatic send_matrix(input int unsigned count);
    repeat (count) send_distance(pick_distance());
  endtask

  // Drop push, drain every owed result, then let the pipeline run dry.
  task automatic wait_idle();
    @(negedge clk_i);
    push = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register, then read it back; call only while idle.
  task automatic program_reg(input reg_idx_e idx, input logic [APB_DW-1:0] data);
    logic [APB_DW-1:0] readback;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(idx, data);
    // go straight into the read setup cycle
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    if (readback !== tracker.read_reg(idx)) begin
      $display("%0t: register %s readback expected %0d actual %0d", $time, idx.name(),
               tracker.read_reg(idx), readback);
      tracker.mismatches++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic configure(input int unsigned side, input logic [DIST_W-1:0] thr,
                           input bit write_side);
    wait_idle();
    if (write_side) program_reg(REG_FRAME_COUNT, APB_DW'(side));
    program_reg(REG_MIN_THRESHOLD, APB_DW'(thr));
  endtask

  // Whole matrices with random content, with the odd truncated one; keep going
  // until enough elements went in and enough tile minima came out.
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned min_items);
    int unsigned sent;
    int unsigned first_result;
    int unsigned side;
    int unsigned eff;
    int unsigned count;
    bit          rewrite;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent           = 0;
    first_result   = tracker.predicted;
    side           = 32'(tracker.frame_count);
    rewrite        = 1'b1;
    while ((sent < min_items || tracker.predicted - first_result < 12) &&
           sent < 4 * min_items) begin
      if (rewrite) side = pick_side();
      configure(side, pick_threshold(), rewrite);
      eff = (side == 0) ? 1 : side;
      repeat ($urandom_range(1, 3)) begin
        count = eff * eff;
        // cut a matrix short now and then; the next frame write restarts it
        if ($urandom_range(7) == 0) count = $urandom_range(1, count);
        send_matrix(count);
        sent += count;
      end
      // sometimes keep the frame running and change only the threshold
      rewrite = ($urandom_range(3) != 0);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    push       = 1'b0;
    distance_i = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a 2x2 frame; the two off-diagonal elements tie and the first
    // in row-major order must win, while the zero diagonal is ignored.
    configure(2, DIST_MAX, 1'b1);
    send_distance('0);
    send_distance(DIST_W'(5));
    send_distance(DIST_W'(5));
    send_distance('0);
    // next matrix after the wrap: nothing strictly below the sentinel, no result
    send_distance(DIST_W'(1));
    send_distance(SENTINEL);
    send_distance(DIST_MAX);
    send_distance(DIST_W'(1));
    // just below the sentinel loses to zero in the lower triangle
    send_distance(DIST_W'(7));
    send_distance(DIST_W'(SENTINEL - 1));
    send_distance('0);
    send_distance(DIST_W'(9));
    // single-element frame: all diagonal, never emits
    configure(1, DIST_MAX, 1'b1);
    send_distance(DIST_MAX);
    send_distance('0);
    // frame count zero behaves as one
    configure(0, DIST_MAX, 1'b1);
    send_distance('0);
    send_distance(DIST_W'(3));
    // zero threshold suppresses every tile
    configure(2, '0, 1'b1);
    send_distance(DIST_W'(1));
    send_distance('0);
    send_distance(DIST_W'(2));
    send_distance(DIST_W'(4));
    // oversized frame count clamps to the maximum; stream a few then restart
    configure((1 << FC_W) - 1, SENTINEL, 1'b1);
    send_distance('0);
    send_distance(DIST_W'(1));
    send_distance(DIST_MAX);

    // Two rows of a frame just past the window: the column tile index
    // advances across the boundary; the next frame write restarts it.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(WIN + 1, DIST_MAX, 1'b1);
    send_matrix(2 * (WIN + 1));

    // Random phases with different idling patterns.
    run_phase(0, 0, 150);
    run_phase(53, 0, 150);
    run_phase(0, 53, 150);
    run_phase(15, 15, 150);

    // Backpressure: hold the receiver off long enough that the result FIFO and
    // the input queue fill while the sender keeps offering 2x2 frames.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(2, DIST_MAX, 1'b1);
    pop_hold = 400;
    repeat (240) send_distance(DIST_W'($urandom_range(0, SENTINEL - 1)));

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
